FILE: hw/rtl/matrix_determinant_top_macros.svh
// assertion helpers for the matrix determinant block
`ifndef MATRIX_DETERMINANT_TOP_MACROS_SVH
`define MATRIX_DETERMINANT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every clock edge out of reset
`define MDET_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mdet assertion failed");
// condition never occurs out of reset
`define MDET_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mdet forbidden condition seen");
`else
`define MDET_ASSERT(lbl, prop)
`define MDET_NEVER(lbl, cond)
`endif

`endif

FILE: hw/rtl/mdet_pkg.sv
`timescale 1ns / 1ps
package mdet_pkg;

  localparam int MAX_ORDER_DEF = 4;
  localparam int ENTRY_W       = 16;
  localparam int DET_W         = 64;
  localparam int CFG_W         = 4;
  // holds any minor of 16-bit entries up to order 8 without wrap
  localparam int ACC_W         = 136;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_MUL,
    ST_WRITE,
    ST_DONE
  } mdet_state_e;

  typedef struct packed {
    logic             busy;
    logic             valid;
    logic [DET_W-1:0] det;
    logic             ovf;
  } mdet_stat_t;

endpackage

FILE: hw/rtl/mdet_ram.sv
`timescale 1ns / 1ps
module mdet_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/mdet_core.sv
`timescale 1ns / 1ps
`include "matrix_determinant_top_macros.svh"
module mdet_core #(
  parameter int MAX_ORDER = mdet_pkg::MAX_ORDER_DEF,
  localparam int ORD_W    = $clog2(MAX_ORDER + 1),
  localparam int ST_D     = MAX_ORDER * MAX_ORDER,
  localparam int ST_AW    = (ST_D > 1) ? $clog2(ST_D) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ORD_W-1:0]             order_i,
  output logic                         e_re_o,
  output logic [ST_AW-1:0]             e_raddr_o,
  input  logic [mdet_pkg::ENTRY_W-1:0] e_rdata_i,
  output mdet_pkg::mdet_stat_t         stat_o
);

  localparam int SET_W = MAX_ORDER;
  localparam int SET_D = 1 << MAX_ORDER;
  localparam int SAW   = (SET_D > 1) ? $clog2(SET_D) : 1;
  localparam int ACC_W = mdet_pkg::ACC_W;
  localparam int DET_W = mdet_pkg::DET_W;

  mdet_pkg::mdet_state_e state_q, state_d;
  logic [SET_W-1:0] set_q, set_d;
  logic [ORD_W-1:0] col_q, col_d;
  logic [3:0]       bit_q, bit_d;
  logic             neg_q, neg_d;
  logic [ACC_W-1:0] acc_q, acc_d;

  logic             re;
  logic             m_we;
  logic [SAW-1:0]   m_waddr;
  logic [ACC_W-1:0] m_wdata;
  logic [SAW-1:0]   m_raddr;
  logic [ACC_W-1:0] m_rdata;

  logic [SET_W:0]   full_w;
  logic [SET_W-1:0] full;
  logic             hit;
  logic             col_end;
  logic [ORD_W-1:0] row;
  logic [31:0]      e_idx;
  logic [ACC_W-1:0] shifted;
  logic             sub;
  logic             fits;

  // subset bookkeeping: minors are indexed by their column set
  assign full_w  = ((SET_W + 1)'(1)) << order_i;
  assign full    = SET_W'(full_w - (SET_W + 1)'(1));
  assign hit     = ((set_q >> col_q) & SET_W'(1)) != '0;
  assign col_end = col_q >= order_i;
  assign row     = order_i - ORD_W'($countones(set_q));
  assign e_idx   = 32'(row) * 32'(MAX_ORDER) + 32'(col_q);

  // one shift-add step of entry times minor, msb carries negative weight
  assign shifted = m_rdata << bit_q;
  assign sub     = neg_q ^ (bit_q == 4'd15);
  assign fits    = (&acc_q[ACC_W-1:DET_W-1]) || !(|acc_q[ACC_W-1:DET_W-1]);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdet_pkg::ST_IDLE:  if (start_i) state_d = mdet_pkg::ST_INIT;
      mdet_pkg::ST_INIT:  state_d = mdet_pkg::ST_SCAN;
      mdet_pkg::ST_SCAN: begin
        if (col_end) state_d = mdet_pkg::ST_WRITE;
        else if (hit) state_d = mdet_pkg::ST_MUL;
      end
      mdet_pkg::ST_MUL:   if (bit_q == 4'd15) state_d = mdet_pkg::ST_SCAN;
      mdet_pkg::ST_WRITE: begin
        if (set_q == full) state_d = mdet_pkg::ST_DONE;
        else state_d = mdet_pkg::ST_SCAN;
      end
      mdet_pkg::ST_DONE:  state_d = mdet_pkg::ST_IDLE;
      default:            state_d = mdet_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    set_d   = set_q;
    col_d   = col_q;
    bit_d   = bit_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    re      = 1'b0;
    m_we    = 1'b0;
    m_waddr = '0;
    m_wdata = acc_q;
    m_raddr = SAW'(set_q & ~(SET_W'(1) << col_q));
    unique case (state_q)
      mdet_pkg::ST_INIT: begin
        // empty minor has determinant one
        m_we    = 1'b1;
        m_wdata = ACC_W'(1);
        set_d   = SET_W'(1);
        col_d   = '0;
        neg_d   = 1'b0;
        acc_d   = '0;
      end
      mdet_pkg::ST_SCAN: begin
        if (!col_end) begin
          col_d = col_q + ORD_W'(1);
          if (hit) begin
            re    = 1'b1;
            bit_d = '0;
          end
        end
      end
      mdet_pkg::ST_MUL: begin
        if (e_rdata_i[bit_q]) begin
          acc_d = sub ? (acc_q - shifted) : (acc_q + shifted);
        end
        bit_d = bit_q + 4'd1;
        if (bit_q == 4'd15) neg_d = !neg_q;
      end
      mdet_pkg::ST_WRITE: begin
        m_we    = 1'b1;
        m_waddr = SAW'(set_q);
        if (set_q != full) begin
          set_d = set_q + SET_W'(1);
          col_d = '0;
          neg_d = 1'b0;
          acc_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdet_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q <= set_d;
    col_q <= col_d;
    bit_q <= bit_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
  end

  // minor determinant store
  mdet_ram #(
    .WIDTH(ACC_W),
    .DEPTH(SET_D)
  ) u_minor_ram (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(m_wdata),
    .re_i   (re),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  assign e_re_o    = re;
  assign e_raddr_o = ST_AW'(e_idx);

  // result with saturation
  always_comb begin
    stat_o.busy  = state_q != mdet_pkg::ST_IDLE;
    stat_o.valid = state_q == mdet_pkg::ST_DONE;
    stat_o.ovf   = !fits;
    if (fits) stat_o.det = acc_q[DET_W-1:0];
    else if (acc_q[ACC_W-1]) stat_o.det = {1'b1, {(DET_W - 1){1'b0}}};
    else stat_o.det = {1'b0, {(DET_W - 1){1'b1}}};
  end

  `MDET_ASSERT(a_start_idle, start_i |-> state_q == mdet_pkg::ST_IDLE)
  `MDET_ASSERT(a_done_pulse, stat_o.valid |=> !stat_o.valid)
  `MDET_NEVER(a_mul_empty_set, state_q == mdet_pkg::ST_MUL && set_q == '0)

endmodule

FILE: hw/rtl/matrix_determinant_top.sv
`timescale 1ns / 1ps
`include "matrix_determinant_top_macros.svh"
// Matrix determinant by cofactor expansion. Entries of an n x n matrix
// (n from matrix_size, 0 read as 1, above MAX_ORDER read as MAX_ORDER) arrive
// in row-major order, one word per cycle while s_axis_tready is high. After
// the last entry the block is busy while one shared shift-add accumulator
// evaluates every column-subset minor from the bottom row up: each of the
// 2^n - 1 subsets takes a scan over the columns, a bitwise shift-add of
// entry times minor for each column it holds and a write, and an init and a
// done state frame the run; the word is valid in the cycle after the last
// busy cycle. The result is saturated to 64 bits and tuser[0] flags
// overflow. A write of matrix_size discards a partly loaded matrix.
module matrix_determinant_top #(
  parameter int MAX_ORDER = mdet_pkg::MAX_ORDER_DEF,
  localparam int ORD_W    = $clog2(MAX_ORDER + 1),
  localparam int ST_D     = MAX_ORDER * MAX_ORDER,
  localparam int ST_AW    = (ST_D > 1) ? $clog2(ST_D) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mdet_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [mdet_pkg::ENTRY_W-1:0]  s_axis_tdata_i,  // [15:0] entry_value
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [mdet_pkg::DET_W-1:0]    m_axis_tdata_o,  // [63:0] determinant
  output logic [0:0]                    m_axis_tuser_o   // [0] overflow
);

  logic [mdet_pkg::CFG_W-1:0] size_q;
  logic [ORD_W-1:0]           order;
  logic [ORD_W-1:0]           row_q, col_q;
  logic                       last_col, last_row, accept, start;
  logic                       out_valid_q;
  logic [mdet_pkg::DET_W-1:0] out_det_q;
  logic                       out_ovf_q;
  logic [31:0]                w_idx;
  logic                       e_re;
  logic [ST_AW-1:0]           e_raddr;
  logic [mdet_pkg::ENTRY_W-1:0] e_rdata;
  mdet_pkg::mdet_stat_t       stat;

  // effective matrix order
  always_comb begin
    priority if (size_q == '0) order = ORD_W'(1);
    else if (32'(size_q) > 32'(MAX_ORDER)) order = ORD_W'(MAX_ORDER);
    else order = ORD_W'(size_q);
  end

  assign last_col        = col_q == order - ORD_W'(1);
  assign last_row        = row_q == order - ORD_W'(1);
  assign s_axis_tready_o = !stat.busy && !(out_valid_q && last_col && last_row);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign start           = accept && last_col && last_row;
  assign w_idx           = 32'(row_q) * 32'(MAX_ORDER) + 32'(col_q);

  // size register and load position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= mdet_pkg::CFG_W'(1);
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
      row_q  <= '0;
      col_q  <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ORD_W'(1);
      end else begin
        col_q <= col_q + ORD_W'(1);
      end
    end
  end

  // entry store
  mdet_ram #(
    .WIDTH(mdet_pkg::ENTRY_W),
    .DEPTH(ST_D)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(ST_AW'(w_idx)),
    .wdata_i(s_axis_tdata_i),
    .re_i   (e_re),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  mdet_core #(
    .MAX_ORDER(MAX_ORDER)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .order_i  (order),
    .e_re_o   (e_re),
    .e_raddr_o(e_raddr),
    .e_rdata_i(e_rdata),
    .stat_o   (stat)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.valid) begin
      out_det_q <= stat.det;
      out_ovf_q <= stat.ovf;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_det_q;
  assign m_axis_tuser_o[0] = out_ovf_q;

  `MDET_NEVER(a_accept_busy, accept && stat.busy)
  `MDET_NEVER(a_result_clobber, stat.valid && out_valid_q)
  `MDET_ASSERT(a_start_busy, start |=> stat.busy)

endmodule
